// ===== rtl/hics_pkg.sv =====
// Package for the histogram inverse-CDF sampler: payload structs, codes,
// controller commands and status, and the saturation helper.
// Depends on nothing.
package hics_pkg;

  localparam int CNT_W = 23;
  localparam logic [15:0] CUM_SCALE = 16'hFFFF;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_FINAL  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ACK   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         bin_index;
    logic signed [23:0] bin_count;
    logic signed [31:0] edge_value;
    logic [15:0]        random_code;
  } hics_in_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [1:0]         status;
  } hics_out_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_LOAD,
    CMD_RES_EMPTY,
    CMD_RES_ACK,
    CMD_FIN_INIT,
    CMD_SUM_RD,
    CMD_SUM_ACC,
    CMD_CUM_INIT,
    CMD_CUM_ACC,
    CMD_CUM_MUL,
    CMD_DIV_START,
    CMD_CUM_WR,
    CMD_FIN_DONE,
    CMD_SRCH_INIT,
    CMD_SRCH_RD,
    CMD_SRCH_CMP,
    CMD_BIN_SET,
    CMD_BIN_RD1,
    CMD_BIN_RD2,
    CMD_BIN_RD3,
    CMD_PREP,
    CMD_MUL,
    CMD_RES_SAMPLE
  } hics_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       ready;
    logic       last;
    logic       total_zero;
    logic       srch_go;
    logic       d_zero;
    logic       div_done;
  } hics_sts_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== rtl/hics_div.sv =====
// Restoring divider for the sampler, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module hics_div #(
  parameter int NW = 49,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [DW:0]   sh;
  logic [DW:0]   diffv;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  assign sh      = {rem_r, q_r[NW-1]};
  assign ge      = sh >= {1'b0, den_r};
  assign diffv   = sh - {1'b0, den_r};
  assign rem_nxt = ge ? diffv[DW-1:0] : sh[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1)) && !start;
      if (start) begin
        cnt_r <= CW'(NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// ===== rtl/hics_datapath.sv =====
// Datapath of the sampler: count, cumulative and edge memories, working
// registers and the divider. Depends on hics_pkg and hics_div.
module hics_datapath #(
  parameter int MAX_BINS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hics_pkg::hics_in_t  in_item,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data,
  input  hics_pkg::hics_cmd_t cmd,
  output hics_pkg::hics_sts_t sts,
  output hics_pkg::hics_out_t result
);
  import hics_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int IW = $clog2(MAX_BINS + 1);
  localparam int TW = CNT_W + IW;
  localparam int NW = (16 + TW > 49) ? 16 + TW : 49;
  localparam logic [IW-1:0] NMAX = IW'(MAX_BINS);

  hics_in_t            item_r;
  hics_out_t           result_r;
  logic [8:0]          bins_r;
  logic                ready_r;
  logic [IW-1:0]       n_r, i_r, lo_r, hi_r, bin_r;
  logic [TW-1:0]       total_r, run_r;
  logic [15:0]         base_r, cumb_r, d_r, diff_r;
  logic signed [31:0]  lo_edge_r, hi_edge_r;
  logic signed [32:0]  width_r;
  logic [NW-1:0]       num_r;
  logic [TW-1:0]       den_r;
  logic                neg_r;

  logic [CNT_W-1:0]    cnt_mem [MAX_BINS];
  logic [15:0]         cum_mem [MAX_BINS];
  logic [31:0]         edge_mem [MAX_BINS+1];
  logic [CNT_W-1:0]    cnt_rd_r;
  logic [15:0]         cum_rd_r;
  logic [31:0]         edge_rd_r;

  logic [IW+7:0]       idx_wide;
  logic                idx_ok;
  logic [IW-1:0]       idx_a;
  logic [IW+8:0]       bins_wide;
  logic [IW-1:0]       active;
  logic [IW:0]         mid_sum;
  logic [IW-1:0]       mid;
  logic [IW-1:0]       cnt_ra, cum_ra, edge_ra, edge_wa;
  logic                edge_we;
  logic [CNT_W-1:0]    cnt_clamp;
  logic [TW+15:0]      cum_prod;
  logic [32:0]         wabs;
  logic [48:0]         smp_prod;
  logic signed [33:0]  w_ext, w_rnd, half;
  logic signed [34:0]  lo35, half35, qv, mid_val, fin_val;
  logic                div_start, div_done;
  logic [NW-1:0]       quo;

  assign idx_wide  = {{IW{1'b0}}, item_r.bin_index};
  assign idx_ok    = idx_wide < (IW+8)'(MAX_BINS);
  assign idx_a     = idx_wide[IW-1:0];
  assign bins_wide = {{IW{1'b0}}, bins_r};
  assign active    = (bins_r == 9'd0) ? IW'(1) :
                     (bins_wide > (IW+9)'(MAX_BINS)) ? NMAX : bins_wide[IW-1:0];
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[IW:1];
  assign cnt_clamp = item_r.bin_count[23] ? '0 : item_r.bin_count[CNT_W-1:0];

  assign cum_prod = run_r * CUM_SCALE;
  assign wabs     = width_r[32] ? 33'(-width_r) : 33'(width_r);
  assign smp_prod = wabs * diff_r;

  assign w_ext   = {width_r[32], width_r};
  assign w_rnd   = w_ext + $signed({33'd0, width_r[32]});
  assign half    = w_rnd >>> 1;
  assign lo35    = {{3{lo_edge_r[31]}}, lo_edge_r};
  assign half35  = {half[33], half};
  assign mid_val = lo35 + half35;
  assign qv      = {2'b00, quo[32:0]};
  assign fin_val = neg_r ? (lo35 - qv) : (lo35 + qv);

  always_comb begin
    cnt_ra  = i_r;
    cum_ra  = i_r;
    edge_ra = bin_r;
    edge_wa = idx_a;
    edge_we = 1'b0;
    case (cmd)
      CMD_SRCH_RD: cum_ra = mid;
      CMD_BIN_RD1: cum_ra = bin_r - IW'(1);
      CMD_BIN_RD2: begin
        cum_ra  = bin_r;
        edge_ra = bin_r + IW'(1);
      end
      CMD_LOAD:     edge_we = idx_ok;
      CMD_FIN_INIT: begin
        edge_we = 1'b1;
        edge_wa = active;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD && idx_ok) begin
      cnt_mem[idx_a[AW-1:0]] <= cnt_clamp;
    end
    cnt_rd_r <= cnt_mem[cnt_ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_CUM_WR) begin
      cum_mem[i_r[AW-1:0]] <= quo[15:0];
    end
    cum_rd_r <= cum_mem[cum_ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= item_r.edge_value;
    end
    edge_rd_r <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r  <= 9'd256;
      ready_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        bins_r <= cfg_data;
      end
      case (cmd)
        CMD_LOAD: begin
          if (idx_ok) begin
            ready_r <= 1'b0;
          end
        end
        CMD_FIN_INIT:  ready_r <= 1'b0;
        CMD_FIN_DONE:  ready_r <= 1'b1;
        default: ;
      endcase
    end
    case (cmd)
      CMD_LATCH: item_r <= in_item;
      CMD_LOAD, CMD_RES_ACK, CMD_FIN_DONE: begin
        result_r.sample_value <= '0;
        result_r.status       <= ST_ACK;
      end
      CMD_RES_EMPTY: begin
        result_r.sample_value <= '0;
        result_r.status       <= ST_EMPTY;
      end
      CMD_FIN_INIT: begin
        n_r     <= active;
        i_r     <= '0;
        total_r <= '0;
      end
      CMD_SUM_ACC: begin
        total_r <= total_r + TW'(cnt_rd_r);
        i_r     <= i_r + IW'(1);
      end
      CMD_CUM_INIT: begin
        i_r   <= '0;
        run_r <= '0;
        den_r <= total_r;
      end
      CMD_CUM_ACC: run_r <= run_r + TW'(cnt_rd_r);
      CMD_CUM_MUL: num_r <= NW'(cum_prod);
      CMD_CUM_WR:  i_r <= i_r + IW'(1);
      CMD_SRCH_INIT: begin
        lo_r <= '0;
        hi_r <= n_r;
      end
      CMD_SRCH_CMP: begin
        if (cum_rd_r > item_r.random_code) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid + IW'(1);
        end
      end
      CMD_BIN_SET: bin_r <= (lo_r >= n_r) ? n_r - IW'(1) : lo_r;
      CMD_BIN_RD2: begin
        base_r    <= (bin_r == '0) ? 16'd0 : cum_rd_r;
        lo_edge_r <= edge_rd_r;
      end
      CMD_BIN_RD3: begin
        cumb_r    <= cum_rd_r;
        hi_edge_r <= edge_rd_r;
      end
      CMD_PREP: begin
        d_r     <= cumb_r - base_r;
        width_r <= {hi_edge_r[31], hi_edge_r} - {lo_edge_r[31], lo_edge_r};
        diff_r  <= item_r.random_code - base_r;
      end
      CMD_MUL: begin
        num_r <= NW'(smp_prod);
        den_r <= TW'(d_r);
        neg_r <= width_r[32];
        if (d_r == 16'd0) begin
          result_r.sample_value <= sat_s32(mid_val);
          result_r.status       <= ST_OK;
        end
      end
      CMD_RES_SAMPLE: begin
        result_r.sample_value <= sat_s32(fin_val);
        result_r.status       <= ST_OK;
      end
      default: ;
    endcase
  end

  assign div_start = (cmd == CMD_DIV_START);

  hics_div #(
    .NW(NW),
    .DW(TW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (num_r),
    .den  (den_r),
    .done (div_done),
    .quo  (quo)
  );

  always_comb begin
    sts.op         = item_r.op;
    sts.ready      = ready_r;
    sts.last       = ({1'b0, i_r} + (IW+1)'(1)) == {1'b0, n_r};
    sts.total_zero = (total_r == '0);
    sts.srch_go    = lo_r < hi_r;
    sts.d_zero     = (d_r == 16'd0);
    sts.div_done   = div_done;
  end

  assign result = result_r;
endmodule

// ===== rtl/hics_ctrl.sv =====
// Controller state machine of the sampler: sequences load, finalize and
// sample items over the datapath. Depends on hics_pkg.
module hics_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  hics_pkg::hics_sts_t sts,
  output hics_pkg::hics_cmd_t cmd,
  output logic                busy,
  output logic                out_valid
);
  import hics_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOAD, S_FIN_TOP, S_SUM_A, S_SUM_B, S_FIN_CHK,
    S_CUM_A, S_CUM_B, S_CUM_MUL, S_CUM_DIV, S_CUM_WAIT, S_FIN_END,
    S_SRCH_INIT, S_SRCH_RD, S_SRCH_CMP, S_BIN_RD1, S_BIN_RD2, S_BIN_RD3,
    S_PREP, S_MUL, S_SMP_DIV, S_SMP_WAIT, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_LOAD:  state_nxt = S_LOAD;
          OP_FINAL: state_nxt = S_FIN_TOP;
          OP_SAMPLE: begin
            if (sts.ready) begin
              state_nxt = S_SRCH_INIT;
            end else begin
              cmd       = CMD_RES_EMPTY;
              state_nxt = S_RESP;
            end
          end
          default: begin
            cmd       = CMD_RES_ACK;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_LOAD: begin
        cmd       = CMD_LOAD;
        state_nxt = S_RESP;
      end
      S_FIN_TOP: begin
        cmd       = CMD_FIN_INIT;
        state_nxt = S_SUM_A;
      end
      S_SUM_A: begin
        cmd       = CMD_SUM_RD;
        state_nxt = S_SUM_B;
      end
      S_SUM_B: begin
        cmd       = CMD_SUM_ACC;
        state_nxt = sts.last ? S_FIN_CHK : S_SUM_A;
      end
      S_FIN_CHK: begin
        if (sts.total_zero) begin
          cmd       = CMD_RES_EMPTY;
          state_nxt = S_RESP;
        end else begin
          cmd       = CMD_CUM_INIT;
          state_nxt = S_CUM_A;
        end
      end
      S_CUM_A: begin
        cmd       = CMD_SUM_RD;
        state_nxt = S_CUM_B;
      end
      S_CUM_B: begin
        cmd       = CMD_CUM_ACC;
        state_nxt = S_CUM_MUL;
      end
      S_CUM_MUL: begin
        cmd       = CMD_CUM_MUL;
        state_nxt = S_CUM_DIV;
      end
      S_CUM_DIV: begin
        cmd       = CMD_DIV_START;
        state_nxt = S_CUM_WAIT;
      end
      S_CUM_WAIT: begin
        if (sts.div_done) begin
          cmd       = CMD_CUM_WR;
          state_nxt = sts.last ? S_FIN_END : S_CUM_A;
        end
      end
      S_FIN_END: begin
        cmd       = CMD_FIN_DONE;
        state_nxt = S_RESP;
      end
      S_SRCH_INIT: begin
        cmd       = CMD_SRCH_INIT;
        state_nxt = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (sts.srch_go) begin
          cmd       = CMD_SRCH_RD;
          state_nxt = S_SRCH_CMP;
        end else begin
          cmd       = CMD_BIN_SET;
          state_nxt = S_BIN_RD1;
        end
      end
      S_SRCH_CMP: begin
        cmd       = CMD_SRCH_CMP;
        state_nxt = S_SRCH_RD;
      end
      S_BIN_RD1: begin
        cmd       = CMD_BIN_RD1;
        state_nxt = S_BIN_RD2;
      end
      S_BIN_RD2: begin
        cmd       = CMD_BIN_RD2;
        state_nxt = S_BIN_RD3;
      end
      S_BIN_RD3: begin
        cmd       = CMD_BIN_RD3;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd       = CMD_PREP;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd       = CMD_MUL;
        state_nxt = sts.d_zero ? S_RESP : S_SMP_DIV;
      end
      S_SMP_DIV: begin
        cmd       = CMD_DIV_START;
        state_nxt = S_SMP_WAIT;
      end
      S_SMP_WAIT: begin
        if (sts.div_done) begin
          cmd       = CMD_RES_SAMPLE;
          state_nxt = S_RESP;
        end
      end
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == S_RESP);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == S_IDLE) |=> (state_r == S_DISPATCH))
    else $error("accepted item did not reach dispatch");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> (!out_valid_r && state_r == S_IDLE))
    else $error("result strobe longer than one cycle");
  a_empty_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISPATCH && sts.op == OP_SAMPLE && !sts.ready) |=> out_valid_r)
    else $error("sample on empty table not answered at once");
  a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SMP_WAIT && sts.div_done) |=> out_valid_r)
    else $error("finished division did not produce a result");
`endif
endmodule

// ===== rtl/histogram_inverse_cdf_sampler_top.sv =====
// Top level of the histogram inverse-CDF sampler.
// Depends on hics_pkg, hics_ctrl and hics_datapath.
//
// One item is taken when start is high and busy is low; its single result
// appears for exactly one cycle with out_valid and cannot be stalled. The next
// item can be taken once busy is low again after the strobe cycle. A load, an
// unused op or a sample on an empty table goes straight to its answer. A sample
// runs a binary search, each step a memory read and then a compare, and then
// the NW steps (49 at 256 bins) of the one-bit-per-cycle divider, unless the
// bin's cumulative step is zero. A finalize walks the bins twice, once for the
// sum and once for the table, each table entry through the same divider.
module histogram_inverse_cdf_sampler_top #(
  parameter int MAX_BINS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hics_pkg::hics_in_t  in_item,
  output logic                out_valid,
  output hics_pkg::hics_out_t out_item,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data
);
  import hics_pkg::*;

  hics_cmd_t cmd;
  hics_sts_t sts;

  hics_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  hics_datapath #(
    .MAX_BINS(MAX_BINS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts),
    .result  (out_item)
  );
endmodule

// ===== sim/tb_top.sv =====
// Testbench for histogram_inverse_cdf_sampler_top: directed table, then random
// load/finalize/sample phases checked against an in-bench predictor.
// Depends on hics_pkg and the RTL of the sampler.
`timescale 1ns / 100ps

module tb_top;
  import hics_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NBINS = 256;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    hics_in_t  item;
    bit        typed;
    hics_out_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  hics_in_t  in_item;
  logic      out_valid;
  hics_out_t out_item;
  logic      cfg_we;
  logic [8:0] cfg_data;

  logic [22:0]        count_mem [NBINS];
  logic [15:0]        cum_mem   [NBINS];
  logic signed [31:0] edge_mem  [NBINS+1];
  bit                 loaded    [NBINS];
  bit                 hist_ready;
  int                 hist_bins;
  logic [8:0]         bins_reg;

  hics_out_t pending_results[$];
  stim_row_t dir_rows[$];
  int errors;
  int cycles;
  int items_sent;
  int samples_ok;
  int phases;

  histogram_inverse_cdf_sampler_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    hics_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %0d/%0d", $time,
                 out_item.sample_value, out_item.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.sample_value !== want.sample_value) begin
          $display("%0t sample_value mismatch: expected %0d actual %0d", $time,
                   want.sample_value, out_item.sample_value);
          errors++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time,
                   want.status, out_item.status);
          errors++;
        end
      end
    end
  end

  function automatic int eff_bins();
    int n;
    n = bins_reg;
    if (n == 0) n = 1;
    if (n > NBINS) n = NBINS;
    return n;
  endfunction

  function automatic hics_out_t predict_result(hics_in_t it);
    hics_out_t res;
    longint total, run, lo, width, v;
    int n, lo_i, hi_i, mid, bin, base, d;
    res.sample_value = '0;
    res.status = ST_ACK;
    case (it.op)
      OP_LOAD: begin
        count_mem[it.bin_index] = it.bin_count[23] ? 23'd0 : it.bin_count[22:0];
        edge_mem[it.bin_index] = it.edge_value;
        hist_ready = 1'b0;
      end
      OP_FINAL: begin
        n = eff_bins();
        edge_mem[n] = it.edge_value;
        total = 0;
        for (int i = 0; i < n; i++) total += count_mem[i];
        hist_bins = n;
        if (total == 0) begin
          hist_ready = 1'b0;
          res.status = ST_EMPTY;
        end else begin
          run = 0;
          for (int i = 0; i < n; i++) begin
            run += count_mem[i];
            cum_mem[i] = 16'((65535 * run) / total);
          end
          hist_ready = 1'b1;
        end
      end
      OP_SAMPLE: begin
        if (!hist_ready) begin
          res.status = ST_EMPTY;
        end else begin
          lo_i = 0;
          hi_i = hist_bins;
          while (lo_i < hi_i) begin
            mid = (lo_i + hi_i) / 2;
            if (cum_mem[mid] > it.random_code) hi_i = mid;
            else lo_i = mid + 1;
          end
          bin = (lo_i >= hist_bins) ? hist_bins - 1 : lo_i;
          base = (bin > 0) ? cum_mem[bin-1] : 0;
          d = int'(cum_mem[bin]) - base;
          lo = edge_mem[bin];
          width = longint'(edge_mem[bin+1]) - lo;
          if (d > 0) v = lo + (width * (longint'(it.random_code) - base)) / d;
          else v = lo + width / 2;
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          res.sample_value = v[31:0];
          res.status = ST_OK;
          samples_ok++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(hics_in_t it, bit typed, hics_out_t want);
    hics_out_t pred;
    int g;
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pred = predict_result(it);
    if (it.op == OP_LOAD) loaded[it.bin_index] = 1'b1;
    pending_results.push_back(typed ? want : pred);
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_bins(logic [8:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bins_reg = v;
  endtask

  function automatic hics_in_t mk(logic [1:0] op, logic [7:0] idx, logic signed [23:0] cnt,
                                  logic signed [31:0] edv, logic [15:0] r);
    hics_in_t it;
    it.op = op;
    it.bin_index = idx;
    it.bin_count = cnt;
    it.edge_value = edv;
    it.random_code = r;
    return it;
  endfunction

  function automatic void add_row(hics_in_t it, bit typed, logic signed [31:0] sv,
                                  logic [1:0] st);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.want.sample_value = sv;
    row.want.status = st;
    dir_rows.push_back(row);
  endfunction

  function automatic logic signed [23:0] rand_count();
    int p;
    p = $urandom_range(99);
    if (p < 15) return 24'sd0;
    if (p < 30) return -24'($urandom_range(1, 8388608));
    if (p < 40) return 24'($urandom());
    return 24'($urandom_range(1, 1000));
  endfunction

  task automatic run_phase(logic [8:0] cfg_val);
    int n, k;
    logic signed [31:0] ed;
    hics_out_t none;
    none = '0;
    write_bins(cfg_val);
    n = eff_bins();
    ed = ($urandom_range(3) == 0) ? 32'($urandom()) : -32'sd65536 * n;
    for (int i = 0; i < n; i++) begin
      if (!loaded[i] || $urandom_range(9) < 7) begin
        if ($urandom_range(9) == 0) send(mk(OP_LOAD, 8'(i), rand_count(), 32'($urandom()),
                                            16'($urandom())), 0, none);
        else send(mk(OP_LOAD, 8'(i), rand_count(), ed, 16'($urandom())), 0, none);
      end
      ed = ed + 32'($urandom_range(0, 1 << 20));
    end
    if ($urandom_range(7) == 0) send(mk(OP_SAMPLE, 8'($urandom()), 24'($urandom()),
                                        32'($urandom()), 16'($urandom())), 0, none);
    send(mk(OP_FINAL, 8'($urandom()), 24'($urandom()),
            ed + 32'($urandom_range(0, 1 << 20)), 16'($urandom())), 0, none);
    k = $urandom_range(8, 20);
    for (int j = 0; j < k; j++) begin
      case ($urandom_range(19))
        0: send(mk(OP_UNUSED, 8'($urandom()), 24'($urandom()), 32'($urandom()),
                   16'($urandom())), 0, none);
        1: send(mk(OP_LOAD, 8'($urandom_range(n - 1)), rand_count(), 32'($urandom()),
                   16'($urandom())), 0, none);
        2: send(mk(OP_SAMPLE, 8'($urandom()), 24'($urandom()), 32'($urandom()),
                   16'hFFFF), 0, none);
        3: send(mk(OP_SAMPLE, 8'($urandom()), 24'($urandom()), 32'($urandom()),
                   16'h0000), 0, none);
        default: send(mk(OP_SAMPLE, 8'($urandom()), 24'($urandom()), 32'($urandom()),
                         16'($urandom())), 0, none);
      endcase
    end
    phases++;
  endtask

  initial begin
    logic [8:0] cv;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    samples_ok = 0;
    phases = 0;
    hist_ready = 1'b0;
    hist_bins = NBINS;
    bins_reg = 9'd256;
    for (int i = 0; i < NBINS; i++) loaded[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mk(OP_SAMPLE, 8'd0, 24'sd0, 32'sd0, 16'd1234), 1, 32'sd0, ST_EMPTY);
    add_row(mk(OP_UNUSED, 8'hFF, -24'sd1, -32'sd1, 16'hFFFF), 1, 32'sd0, ST_ACK);
    for (int i = 0; i < 4; i++)
      add_row(mk(OP_LOAD, 8'(i), 24'sd0, 32'(i * 10 * 65536), 16'd0), 1, 32'sd0, ST_ACK);
    add_row(mk(OP_FINAL, 8'd0, 24'sd0, 32'sd2621440, 16'd0), 1, 32'sd0, ST_EMPTY);
    add_row(mk(OP_SAMPLE, 8'd0, 24'sd0, 32'sd0, 16'd100), 1, 32'sd0, ST_EMPTY);
    add_row(mk(OP_LOAD, 8'd0, -24'sd8388608, 32'sh80000000, 16'd0), 1, 32'sd0, ST_ACK);
    add_row(mk(OP_LOAD, 8'd1, 24'sd8388607, 32'sd0, 16'd0), 1, 32'sd0, ST_ACK);
    add_row(mk(OP_LOAD, 8'd2, 24'sd1, 32'sd65536, 16'd0), 1, 32'sd0, ST_ACK);
    add_row(mk(OP_LOAD, 8'd3, 24'sd0, 32'sd131072, 16'd0), 1, 32'sd0, ST_ACK);
    add_row(mk(OP_FINAL, 8'd0, 24'sd0, 32'sh7FFFFFFF, 16'd0), 1, 32'sd0, ST_ACK);
    add_row(mk(OP_SAMPLE, 8'd0, 24'sd0, 32'sd0, 16'd0), 0, 32'sd0, ST_OK);
    add_row(mk(OP_SAMPLE, 8'd0, 24'sd0, 32'sd0, 16'hFFFF), 0, 32'sd0, ST_OK);
    add_row(mk(OP_SAMPLE, 8'd0, 24'sd0, 32'sd0, 16'hFFFE), 0, 32'sd0, ST_OK);
    add_row(mk(OP_SAMPLE, 8'd0, 24'sd0, 32'sd0, 16'h7FFF), 0, 32'sd0, ST_OK);
    add_row(mk(OP_SAMPLE, 8'd0, 24'sd0, 32'sd0, 16'd65000), 0, 32'sd0, ST_OK);
    add_row(mk(OP_LOAD, 8'd3, 24'sd5, 32'sd131072, 16'd0), 1, 32'sd0, ST_ACK);
    add_row(mk(OP_SAMPLE, 8'd0, 24'sd0, 32'sd0, 16'd40000), 1, 32'sd0, ST_EMPTY);
    add_row(mk(OP_FINAL, 8'd0, 24'sd0, 32'sh7FFFFFFF, 16'd0), 1, 32'sd0, ST_ACK);
    add_row(mk(OP_SAMPLE, 8'd0, 24'sd0, 32'sd0, 16'd65534), 0, 32'sd0, ST_OK);
    add_row(mk(OP_UNUSED, 8'd0, 24'sd0, 32'sd0, 16'd0), 1, 32'sd0, ST_ACK);

    write_bins(9'd4);
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    run_phase(9'd0);
    run_phase(9'd256);
    run_phase(9'd511);
    run_phase(9'd1);
    run_phase(9'd2);
    while (items_sent < 450) begin
      if ($urandom_range(9) == 0) cv = 9'($urandom_range(9, 40));
      else if ($urandom_range(19) == 0) cv = 9'($urandom_range(257, 511));
      else cv = 9'($urandom_range(1, 8));
      run_phase(cv);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d items in %0d random phases, %0d interpolated samples,",
             items_sent, phases, samples_ok);
    $display("bin settings from 0 to 511 including the full 256-bin table.");
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
